// ----- rtl/sigmoid_activation_unit_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sigmoid activation unit
// Concurrent checks clocked by aclk and disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef SIGMOID_ACTIVATION_UNIT_CORE_ASSERT_SVH
`define SIGMOID_ACTIVATION_UNIT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sau assertion failed");
// next-cycle implication
`define SAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sau assertion failed");
`else
`define SAU_ASSERT_IMP(lbl, ante, cons)
`define SAU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/sau_pkg.sv -----
// ----------------------------------------------------------------------------
// sau_pkg
// Constants, types and curve tables of the sigmoid activation unit.
// ----------------------------------------------------------------------------
package sau_pkg;

    localparam int IN_FRAC_BITS   = 8;
    localparam int OUT_FRAC_BITS  = 16;
    localparam int LUT_DEPTH      = 256;
    localparam int LOGI_SPAN_LOG2 = 4;

    localparam int X_W      = 16;
    localparam int U_W      = 2 * X_W;
    localparam int MAG_W    = U_W - 1;
    localparam int ACT_W    = OUT_FRAC_BITS + 1;
    localparam int OUT_TDATA_W = ((ACT_W + 7) / 8) * 8;

    localparam int LUT_AW   = $clog2(LUT_DEPTH) + 1;
    localparam int ROM_W    = 33;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = ROM_W + FRAC_W;
    localparam int LOOK_W   = ROM_W + 1;

    // reciprocal 2^(24+2F)/a, a > 2^(2F)
    localparam int QUOT_W        = 24;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_STAGES    = QUOT_W / DIV_STEP_BITS;
    localparam int REM_W         = MAG_W;
    localparam logic [REM_W-1:0] RECIP_SEED = REM_W'(1) << (2 * IN_FRAC_BITS);

    localparam logic [MAG_W-1:0] ONE_IN   = MAG_W'(1) << (2 * IN_FRAC_BITS);
    localparam logic [ACT_W-1:0] ONE_OUT  = ACT_W'(1) << OUT_FRAC_BITS;
    localparam logic [ROM_W-1:0] ROM_ONE  = ROM_W'(1) << 32;
    localparam logic [ROM_W-1:0] ROM_HALF = ROM_W'(1) << 31;
    localparam logic [ROM_W-1:0] ROUND_BIAS = ROM_W'(1) << (31 - OUT_FRAC_BITS);
    localparam logic [LUT_AW-1:0] LUT_LAST = LUT_AW'(LUT_DEPTH);

    localparam logic [63:0] PI_Q28 = 64'd843314856;

    localparam int APB_AW      = 3;
    localparam int REG_SEL_BIT = 2;
    localparam int APB_DW      = 32;

    typedef enum logic [1:0] {
        CURVE_ATAN     = 2'd0,
        CURVE_LOGISTIC = 2'd1,
        CURVE_LINEAR   = 2'd2,
        CURVE_STEP     = 2'd3
    } curve_mode_t;

    typedef enum logic {
        REG_CURVE_MODE = 1'b0,
        REG_GAIN_ALPHA = 1'b1
    } reg_idx_t;

    localparam curve_mode_t       MODE_RESET  = CURVE_LOGISTIC;
    localparam logic signed [X_W-1:0] ALPHA_RESET = 16'sd256;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [ACT_W-1:0] fixed_act;
    } sau_side_t;

    typedef logic [LUT_DEPTH:0][ROM_W-1:0] rom_t;

    // unsigned 64-bit restoring long division, used for table contents only
    function automatic logic [63:0] const_div(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] const_mod(input logic [63:0] num, input logic [63:0] den);
        return num - const_div(num, den) * den;
    endfunction

    // atan(k/D)/pi with 32 fraction bits, built from the arctan addition series
    function automatic rom_t build_atan_rom();
        rom_t        rom;
        logic [63:0] d;
        logic [63:0] kk;
        logic [63:0] m;
        logic [63:0] p1;
        logic [63:0] p3;
        logic [63:0] p5;
        logic [63:0] p7;
        logic [63:0] acc;
        rom = '0;
        d   = 64'(LUT_DEPTH);
        acc = '0;
        for (int k = 1; k <= LUT_DEPTH; k++) begin
            kk  = 64'(k);
            m   = d * d + kk * (kk - 64'd1);
            p1  = const_div(d << 48, m);
            p3  = const_div(const_div(p1 * d, m) * d, m);
            p5  = const_div(const_div(p3 * d, m) * d, m);
            p7  = const_div(const_div(p5 * d, m) * d, m);
            acc = acc + p1 - const_div(p3, 64'd3) + const_div(p5, 64'd5)
                  - const_div(p7, 64'd7);
            rom[k] = ROM_W'(const_div(acc << 12, PI_Q28));
        end
        return rom;
    endfunction

    // 1/(1+exp(-16k/D)) with 32 fraction bits
    function automatic rom_t build_logi_rom();
        rom_t        rom;
        logic [63:0] one;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] ek;
        logic [63:0] den;
        logic [63:0] big;
        logic [63:0] q;
        logic [63:0] r;
        rom  = '0;
        one  = 64'h1_0000_0000;
        big  = 64'h8000_0000_0000_0000;
        s    = const_div(64'd1 << (32 + LOGI_SPAN_LOG2), 64'(LUT_DEPTH));
        term = one;
        e    = one;
        for (int n = 1; n <= 16; n++) begin
            term = const_div((term * s) >> 32, 64'(n));
            if ((n & 1) != 0) begin
                e = e - term;
            end else begin
                e = e + term;
            end
        end
        ek = one;
        for (int k = 0; k <= LUT_DEPTH; k++) begin
            den    = one + ek;
            q      = const_div(big, den);
            r      = const_mod(big, den);
            rom[k] = ROM_W'(64'd2 * q + const_div(64'd2 * r, den));
            ek     = (ek * e) >> 32;
        end
        return rom;
    endfunction

    localparam rom_t ATAN_ROM = build_atan_rom();
    localparam rom_t LOGI_ROM = build_logi_rom();

endpackage

// ----- rtl/sau_recip_div.sv -----
// ----------------------------------------------------------------------------
// sau_recip_div
// Pipelined restoring divider for the arctan reciprocal, two quotient bits
// per stage; side data travels with each stage.
// ----------------------------------------------------------------------------
module sau_recip_div import sau_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  sau_side_t         in_side,
    output logic              out_vld,
    output sau_side_t         out_side,
    output logic [QUOT_W-1:0] out_quot
);

    logic              vld_reg  [DIV_STAGES];
    sau_side_t         side_reg [DIV_STAGES];
    logic [REM_W-1:0]  rem_reg  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_reg [DIV_STAGES];

    logic              vld_in   [DIV_STAGES];
    sau_side_t         side_in  [DIV_STAGES];
    logic [REM_W-1:0]  rem_in   [DIV_STAGES];
    logic [QUOT_W-1:0] quot_in  [DIV_STAGES];

    logic [REM_W-1:0]  rem_next  [DIV_STAGES];
    logic [QUOT_W-1:0] quot_next [DIV_STAGES];

    assign vld_in[0]  = in_vld;
    assign side_in[0] = in_side;
    assign rem_in[0]  = RECIP_SEED;
    assign quot_in[0] = '0;

    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
        assign vld_in[g]  = vld_reg[g-1];
        assign side_in[g] = side_reg[g-1];
        assign rem_in[g]  = rem_reg[g-1];
        assign quot_in[g] = quot_reg[g-1];
    end

    always_comb begin : div_step
        logic [REM_W-1:0]  r;
        logic [REM_W:0]    trial;
        logic [QUOT_W-1:0] q;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r = rem_in[s];
            q = quot_in[s];
            for (int b = 0; b < DIV_STEP_BITS; b++) begin
                trial = {r, 1'b0};
                if (trial >= {1'b0, side_in[s].mag}) begin
                    r = REM_W'(trial - {1'b0, side_in[s].mag});
                    q = {q[QUOT_W-2:0], 1'b1};
                end else begin
                    r = trial[REM_W-1:0];
                    q = {q[QUOT_W-2:0], 1'b0};
                end
            end
            rem_next[s]  = r;
            quot_next[s] = q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                vld_reg[s] <= vld_in[s];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                side_reg[s] <= side_in[s];
                rem_reg[s]  <= rem_next[s];
                quot_reg[s] <= quot_next[s];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];
    assign out_quot = quot_reg[DIV_STAGES-1];

endmodule

// ----- rtl/sigmoid_activation_unit_core.sv -----
// ----------------------------------------------------------------------------
// sigmoid_activation_unit_core
// Streaming activation: arctan, logistic, clamped linear or step curve on a
// signed Q8.8 sample, result in unsigned Q1.16.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled; an input skid
// register decouples s_tready from m_tready. The path from the input transfer
// to m_tvalid runs through the sample, gain multiply and magnitude registers,
// the 12-stage reciprocal divider of the arctan path and the table
// interpolation stages. Curve mode and gain may only be written over APB
// while no sample is in flight.
`include "sigmoid_activation_unit_core_assert.svh"

module sigmoid_activation_unit_core import sau_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // APB configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    // input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [X_W-1:0]         s_tdata,   // [15:0] sample_in
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [16:0] activation_out, rest zero
);

    localparam int ATAN_IDX_LSB = 2 * IN_FRAC_BITS - (LUT_AW - 1);
    localparam int LOGI_IDX_LSB = 2 * IN_FRAC_BITS + LOGI_SPAN_LOG2 - (LUT_AW - 1);
    localparam logic signed [U_W:0] LIN_HALF = (U_W + 1)'(ONE_IN >> 1);
    localparam logic signed [U_W:0] LIN_ONE  = (U_W + 1)'(ONE_IN);

    // ---------------- configuration ----------------
    curve_mode_t             curve_mode_reg;
    logic signed [X_W-1:0]   gain_alpha_reg;
    logic                    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_mode_reg <= MODE_RESET;
            gain_alpha_reg <= ALPHA_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[REG_SEL_BIT]))
                REG_CURVE_MODE: curve_mode_reg <= curve_mode_t'(pwdata[1:0]);
                REG_GAIN_ALPHA: gain_alpha_reg <= signed'(pwdata[X_W-1:0]);
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[REG_SEL_BIT]))
            REG_CURVE_MODE: prdata = {{(APB_DW - 2){1'b0}}, curve_mode_reg};
            REG_GAIN_ALPHA: prdata = {{(APB_DW - X_W){1'b0}}, gain_alpha_reg};
        endcase
    end

    // ---------------- input skid and stall ----------------
    logic                  pipe_en;
    logic                  skid_vld_reg;
    logic [X_W-1:0]        skid_data_reg;
    logic                  in_vld;
    logic [X_W-1:0]        in_x;
    logic                  m_valid_reg;
    logic [ACT_W-1:0]      act_reg;

    assign pipe_en  = !m_valid_reg || m_tready;
    assign s_tready = !skid_vld_reg;
    assign in_vld   = skid_vld_reg || s_tvalid;
    assign in_x     = skid_vld_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            skid_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_tvalid && s_tready) begin
            skid_data_reg <= s_tdata;
        end
    end

    // ---------------- A: sample register ----------------
    logic                  a_vld_reg;
    logic signed [X_W-1:0] a_x_reg;

    // ---------------- B: gain multiply ----------------
    logic                  b_vld_reg;
    logic signed [U_W-1:0] b_u_reg;
    logic                  b_step_reg;

    // ---------------- C: magnitude, linear and step ----------------
    logic                  c_vld_reg;
    sau_side_t             c_side_reg;
    sau_side_t             c_side_next;
    logic signed [U_W:0]   lin_y;
    logic [ACT_W-1:0]      lin_act;

    always_comb begin
        lin_y = (U_W + 1)'(b_u_reg) + LIN_HALF;
        if (lin_y[U_W]) begin
            lin_act = '0;
        end else if (lin_y > LIN_ONE) begin
            lin_act = ONE_OUT;
        end else begin
            lin_act = lin_y[ACT_W-1:0];
        end
        c_side_next.neg = b_u_reg[U_W-1];
        c_side_next.mag = b_u_reg[U_W-1] ? MAG_W'(-b_u_reg) : MAG_W'(b_u_reg);
        if (curve_mode_reg == CURVE_STEP) begin
            c_side_next.fixed_act = b_step_reg ? ONE_OUT : '0;
        end else begin
            c_side_next.fixed_act = lin_act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_x_reg    <= signed'(in_x);
            b_u_reg    <= gain_alpha_reg * a_x_reg;
            b_step_reg <= a_x_reg >= gain_alpha_reg;
            c_side_reg <= c_side_next;
        end
    end

    // ---------------- D: reciprocal for arctan beyond one ----------------
    logic              dv_vld;
    sau_side_t         dv_side;
    logic [QUOT_W-1:0] dv_quot;

    sau_recip_div u_recip_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_vld   (c_vld_reg),
        .in_side  (c_side_reg),
        .out_vld  (dv_vld),
        .out_side (dv_side),
        .out_quot (dv_quot)
    );

    // ---------------- E: table index and fraction ----------------
    logic              e_vld_reg;
    logic [LUT_AW-1:0] e_idx_reg;
    logic [LUT_AW-1:0] e_idx_next;
    logic [FRAC_W-1:0] e_frac_reg;
    logic [FRAC_W-1:0] e_frac_next;
    logic              e_atan_reg;
    logic              e_atan_next;
    logic              e_large_reg;
    logic              e_large_next;
    logic              e_neg_reg;
    logic [ACT_W-1:0]  e_fixed_reg;

    always_comb begin
        e_atan_next  = 1'b1;
        e_large_next = 1'b0;
        case (curve_mode_reg)
            CURVE_LOGISTIC: begin
                e_atan_next = 1'b0;
                if (|dv_side.mag[MAG_W-1:LOGI_IDX_LSB + LUT_AW - 1]) begin
                    e_idx_next  = LUT_LAST;
                    e_frac_next = '0;
                end else begin
                    e_idx_next  = {1'b0, dv_side.mag[LOGI_IDX_LSB +: LUT_AW - 1]};
                    e_frac_next = {dv_side.mag[LOGI_IDX_LSB-1:0],
                                   {(FRAC_W - LOGI_IDX_LSB){1'b0}}};
                end
            end
            default: begin
                if (dv_side.mag <= ONE_IN) begin
                    e_idx_next  = dv_side.mag[ATAN_IDX_LSB +: LUT_AW];
                    e_frac_next = {dv_side.mag[ATAN_IDX_LSB-1:0],
                                   {(FRAC_W - ATAN_IDX_LSB){1'b0}}};
                end else begin
                    e_large_next = 1'b1;
                    e_idx_next   = {1'b0, dv_quot[QUOT_W-1 -: LUT_AW - 1]};
                    e_frac_next  = dv_quot[FRAC_W-1:0];
                end
            end
        endcase
    end

    // ---------------- F: table read ----------------
    logic              f_vld_reg;
    logic [ROM_W-1:0]  f_lo_reg;
    logic [ROM_W-1:0]  f_hi_reg;
    logic [FRAC_W-1:0] f_frac_reg;
    logic              f_atan_reg;
    logic              f_large_reg;
    logic              f_neg_reg;
    logic [ACT_W-1:0]  f_fixed_reg;
    logic [LUT_AW-1:0] hi_idx;

    assign hi_idx = (e_idx_reg == LUT_LAST) ? e_idx_reg : LUT_AW'(e_idx_reg + 1'b1);

    // ---------------- G: step between entries ----------------
    logic              g_vld_reg;
    logic [ROM_W-1:0]  g_lo_reg;
    logic [ROM_W-1:0]  g_diff_reg;
    logic [FRAC_W-1:0] g_frac_reg;
    logic              g_atan_reg;
    logic              g_large_reg;
    logic              g_neg_reg;
    logic [ACT_W-1:0]  g_fixed_reg;

    // ---------------- H: interpolation product ----------------
    logic              h_vld_reg;
    logic [ROM_W-1:0]  h_lo_reg;
    logic [PROD_W-1:0] h_prod_reg;
    logic              h_atan_reg;
    logic              h_large_reg;
    logic              h_neg_reg;
    logic [ACT_W-1:0]  h_fixed_reg;

    // ---------------- I: curve value ----------------
    logic              i_vld_reg;
    logic [ROM_W-1:0]  i_v_reg;
    logic [ROM_W-1:0]  i_v_next;
    logic              i_neg_reg;
    logic [ACT_W-1:0]  i_fixed_reg;
    logic [LOOK_W-1:0] look;
    logic [LOOK_W-1:0] curve;

    always_comb begin
        look = LOOK_W'(h_lo_reg) + LOOK_W'(h_prod_reg[PROD_W-1:FRAC_W]);
        if (!h_atan_reg) begin
            curve = look;
        end else if (!h_large_reg) begin
            curve = LOOK_W'(ROM_HALF) + look;
        end else if (look > LOOK_W'(ROM_ONE)) begin
            curve = '0;
        end else begin
            curve = LOOK_W'(ROM_ONE) - look;
        end
        if (curve > LOOK_W'(ROM_ONE)) begin
            i_v_next = ROM_ONE;
        end else begin
            i_v_next = curve[ROM_W-1:0];
        end
    end

    // ---------------- J: mirror, round, output ----------------
    logic [ROM_W-1:0] mirrored;
    logic [ROM_W-1:0] rounded;
    logic [ACT_W-1:0] act_next;

    always_comb begin
        mirrored = i_neg_reg ? ROM_W'(ROM_ONE - i_v_reg) : i_v_reg;
        rounded  = ROM_W'(mirrored + ROUND_BIAS);
        case (curve_mode_reg) inside
            CURVE_ATAN, CURVE_LOGISTIC: act_next = rounded[ROM_W-1 -: ACT_W];
            default:                    act_next = i_fixed_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            g_vld_reg   <= 1'b0;
            h_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            e_vld_reg   <= dv_vld;
            f_vld_reg   <= e_vld_reg;
            g_vld_reg   <= f_vld_reg;
            h_vld_reg   <= g_vld_reg;
            i_vld_reg   <= h_vld_reg;
            m_valid_reg <= i_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            e_idx_reg   <= e_idx_next;
            e_frac_reg  <= e_frac_next;
            e_atan_reg  <= e_atan_next;
            e_large_reg <= e_large_next;
            e_neg_reg   <= dv_side.neg;
            e_fixed_reg <= dv_side.fixed_act;

            f_lo_reg    <= e_atan_reg ? ATAN_ROM[e_idx_reg] : LOGI_ROM[e_idx_reg];
            f_hi_reg    <= e_atan_reg ? ATAN_ROM[hi_idx] : LOGI_ROM[hi_idx];
            f_frac_reg  <= e_frac_reg;
            f_atan_reg  <= e_atan_reg;
            f_large_reg <= e_large_reg;
            f_neg_reg   <= e_neg_reg;
            f_fixed_reg <= e_fixed_reg;

            g_lo_reg    <= f_lo_reg;
            g_diff_reg  <= (f_hi_reg > f_lo_reg) ? ROM_W'(f_hi_reg - f_lo_reg) : '0;
            g_frac_reg  <= f_frac_reg;
            g_atan_reg  <= f_atan_reg;
            g_large_reg <= f_large_reg;
            g_neg_reg   <= f_neg_reg;
            g_fixed_reg <= f_fixed_reg;

            h_lo_reg    <= g_lo_reg;
            h_prod_reg  <= PROD_W'(g_diff_reg) * PROD_W'(g_frac_reg);
            h_atan_reg  <= g_atan_reg;
            h_large_reg <= g_large_reg;
            h_neg_reg   <= g_neg_reg;
            h_fixed_reg <= g_fixed_reg;

            i_v_reg     <= i_v_next;
            i_neg_reg   <= h_neg_reg;
            i_fixed_reg <= h_fixed_reg;

            act_reg     <= act_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ACT_W){1'b0}}, act_reg};

    // ---------------- checks ----------------
    `SAU_ASSERT_NXT(a_skid_fill, !pipe_en && s_tvalid && s_tready, skid_vld_reg)
    `SAU_ASSERT_NXT(a_stall_freeze, !pipe_en, $stable(a_vld_reg) && $stable(e_vld_reg) && $stable(i_vld_reg))
    `SAU_ASSERT_IMP(a_act_range, m_valid_reg, act_reg <= ONE_OUT)
    `SAU_ASSERT_IMP(a_step_binary, m_valid_reg && curve_mode_reg == CURVE_STEP, act_reg == ONE_OUT || act_reg == '0)

endmodule
